// ===== rtl/bed_pkg.sv =====
// Shared types and constants of the bounded edit distance block.
`default_nettype none

package bed_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BOUND_W = 5;
  localparam int unsigned DIST_W  = 6;

  localparam logic [BOUND_W-1:0] BOUND_RESET = 5'd3;
  localparam logic [DIST_W-1:0]  DIST_SAT    = 6'd63;

  typedef struct packed {
    logic [CHAR_W-1:0] left_char;
    logic              left_valid;
    logic [CHAR_W-1:0] right_char;
    logic              right_valid;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              over_limit;
    logic              truncated;
  } out_item_t;

  // Control part of the row token moving along the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bed_row_src.sv =====
// Left string buffer and row token source feeding the head of the cell chain.
`default_nettype none

module bed_row_src #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic                                               clk_i,
  input  wire logic                                               rst_ni,
  input  wire logic                                               wr_en_i,
  input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]   wr_addr_i,
  input  wire logic [bed_pkg::CHAR_W-1:0]                         wr_data_i,
  input  wire logic                                               start_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]                     n_i,
  output bed_pkg::tok_ctl_t                                       ctl_o,
  output logic      [bed_pkg::CHAR_W-1:0]                         char_o,
  output logic      [$clog2(MAX_LEN + 1)-1:0]                     row_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [bed_pkg::CHAR_W-1:0] mem_q [MAX_LEN];
  logic [bed_pkg::CHAR_W-1:0] rd_data_q;
  logic                       busy_q;
  logic [LW-1:0]              iss_q;
  logic [LW-1:0]              row_q;
  bed_pkg::tok_ctl_t          ctl_q;
  logic [LW-1:0]              iss_nx;

  assign iss_nx = iss_q + LW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[iss_q[AW-1:0]];
    row_q     <= iss_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iss_q  <= '0;
      ctl_q  <= '0;
    end else begin
      ctl_q.valid <= busy_q;
      ctl_q.last  <= busy_q && (iss_nx == n_i);
      if (start_i) begin
        busy_q <= 1'b1;
        iss_q  <= '0;
      end else if (busy_q) begin
        iss_q <= iss_nx;
        if (iss_nx == n_i) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign ctl_o  = ctl_q;
  assign char_o = rd_data_q;
  assign row_o  = row_q;

endmodule

`default_nettype wire

// ===== rtl/bed_cell.sv =====
// One column cell of the systolic edit distance array.
`default_nettype none

module bed_cell #(
  parameter int unsigned MAX_LEN = 32,
  parameter int unsigned COL     = 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_en_i,
  input  wire logic [bed_pkg::CHAR_W-1:0]       wr_data_i,
  input  wire logic                             init_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]   m_i,
  input  wire bed_pkg::tok_ctl_t                in_ctl_i,
  input  wire logic [bed_pkg::CHAR_W-1:0]       in_char_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]   in_left_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]   in_diag_i,
  input  wire logic [$clog2(MAX_LEN + 1)-1:0]   in_min_i,
  output bed_pkg::tok_ctl_t                     out_ctl_o,
  output logic      [bed_pkg::CHAR_W-1:0]       out_char_o,
  output logic      [$clog2(MAX_LEN + 1)-1:0]   out_left_o,
  output logic      [$clog2(MAX_LEN + 1)-1:0]   out_diag_o,
  output logic      [$clog2(MAX_LEN + 1)-1:0]   out_min_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] COL_V = LW'(COL);

  logic [bed_pkg::CHAR_W-1:0] rch_q;
  logic [LW-1:0]              col_q;
  bed_pkg::tok_ctl_t          ctl_q;
  logic [bed_pkg::CHAR_W-1:0] char_q;
  logic [LW-1:0]              left_q;
  logic [LW-1:0]              diag_q;
  logic [LW-1:0]              min_q;

  logic          active;
  logic [LW:0]   up_c;
  logic [LW:0]   left_c;
  logic [LW:0]   diag_c;
  logic [LW:0]   best;
  logic [LW-1:0] val;

  assign active = (m_i >= COL_V);

  always_comb begin
    up_c   = {1'b0, col_q} + (LW+1)'(1);
    left_c = {1'b0, in_left_i} + (LW+1)'(1);
    diag_c = {1'b0, in_diag_i} + (LW+1)'(in_char_i != rch_q);
    best   = (up_c < left_c) ? up_c : left_c;
    best   = (diag_c < best) ? diag_c : best;
    // a cell value never exceeds MAX_LEN
    val    = best[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rch_q <= wr_data_i;
    end
    if (init_i) begin
      col_q <= COL_V;
    end else if (in_ctl_i.valid && active) begin
      col_q <= val;
    end
    char_q <= in_char_i;
    if (active) begin
      left_q <= val;
      diag_q <= col_q;
      min_q  <= (in_min_i < val) ? in_min_i : val;
    end else begin
      left_q <= in_left_i;
      diag_q <= in_diag_i;
      min_q  <= in_min_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= in_ctl_i;
    end
  end

  assign out_ctl_o  = ctl_q;
  assign out_char_o = char_q;
  assign out_left_o = left_q;
  assign out_diag_o = diag_q;
  assign out_min_o  = min_q;

endmodule

`default_nettype wire

// ===== rtl/bounded_edit_distance.sv =====
// Bounded Levenshtein distance: top level with loader, cell chain and result control.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one position of both strings
// per transaction, each byte with its own valid flag; last closes the pair. While
// loading, a transaction is taken every cycle. After last, in_stall_o stays high
// until the result has been placed in the output register.
// Output channel (out_valid_o / out_stall_i / out_item_o): one transaction per pair.
// The output register holds the result under stall while the next pair loads.
// After last, the result skips the cell chain when the length difference exceeds the
// bound or the first string is empty. Otherwise rows of the table enter the chain of
// MAX_LEN column cells one per cycle, and each row crosses the whole chain; the result
// is taken when the last row leaves the chain.
// Config: cfg_we_i writes the bound (cfg_data_i); write only while idle.
// Reset: lengths, truncation flag and bound (to 3) clear; the block is ready at once.
`default_nettype none

module bounded_edit_distance #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bed_pkg::BOUND_W-1:0]  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bed_pkg::in_item_t            in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output bed_pkg::out_item_t                out_item_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned EW = ((LW > bed_pkg::DIST_W) ? LW : bed_pkg::DIST_W) + 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  typedef enum logic [1:0] {
    S_LOAD,
    S_START,
    S_RUN,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [bed_pkg::BOUND_W-1:0]   bound_q;
  logic [LW-1:0]                 llen_q;
  logic [LW-1:0]                 rlen_q;
  logic                          cut_q;
  logic [EW-1:0]                 pend_q;
  logic                          out_valid_q;
  bed_pkg::out_item_t            out_q;

  logic          in_acc;
  logic          ld_left;
  logic          ld_right;
  logic          start;
  logic [EW-1:0] n_e;
  logic [EW-1:0] m_e;
  logic [EW-1:0] b_e;
  logic [EW-1:0] b_plus;
  logic          diff_over;
  logic          can_emit;

  bed_pkg::tok_ctl_t          ctl_w  [MAX_LEN+1];
  logic [bed_pkg::CHAR_W-1:0] char_w [MAX_LEN+1];
  logic [LW-1:0]              left_w [MAX_LEN+1];
  logic [LW-1:0]              diag_w [MAX_LEN+1];
  logic [LW-1:0]              min_w  [MAX_LEN+1];
  logic [LW-1:0]              src_row;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_left    = in_acc && in_item_i.left_valid && (llen_q < LEN_MAX);
  assign ld_right   = in_acc && in_item_i.right_valid && (rlen_q < LEN_MAX);

  assign n_e       = EW'(llen_q);
  assign m_e       = EW'(rlen_q);
  assign b_e       = EW'(bound_q);
  assign b_plus    = b_e + EW'(1);
  assign diff_over = (n_e > m_e + b_e) || (m_e > n_e + b_e);
  assign start     = (state_q == S_START) && !diff_over && (llen_q != '0);
  assign can_emit  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= bed_pkg::BOUND_RESET;
    end else if (cfg_we_i) begin
      bound_q <= cfg_data_i;
    end
  end

  bed_row_src #(
    .MAX_LEN (MAX_LEN)
  ) u_src (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ld_left),
    .wr_addr_i (llen_q[AW-1:0]),
    .wr_data_i (in_item_i.left_char),
    .start_i   (start),
    .n_i       (llen_q),
    .ctl_o     (ctl_w[0]),
    .char_o    (char_w[0]),
    .row_o     (src_row)
  );

  // Column zero of the table: D[r][0] = r.
  assign left_w[0] = src_row;
  assign diag_w[0] = src_row - LW'(1);
  assign min_w[0]  = src_row;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    bed_cell #(
      .MAX_LEN (MAX_LEN),
      .COL     (j + 1)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (ld_right && (rlen_q[AW-1:0] == AW'(j))),
      .wr_data_i  (in_item_i.right_char),
      .init_i     (start),
      .m_i        (rlen_q),
      .in_ctl_i   (ctl_w[j]),
      .in_char_i  (char_w[j]),
      .in_left_i  (left_w[j]),
      .in_diag_i  (diag_w[j]),
      .in_min_i   (min_w[j]),
      .out_ctl_o  (ctl_w[j+1]),
      .out_char_o (char_w[j+1]),
      .out_left_o (left_w[j+1]),
      .out_diag_o (diag_w[j+1]),
      .out_min_o  (min_w[j+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      llen_q      <= '0;
      rlen_q      <= '0;
      cut_q       <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (ld_left) begin
              llen_q <= llen_q + LW'(1);
            end
            if (ld_right) begin
              rlen_q <= rlen_q + LW'(1);
            end
            if ((in_item_i.left_valid && !ld_left) ||
                (in_item_i.right_valid && !ld_right)) begin
              cut_q <= 1'b1;
            end
            if (in_item_i.last) begin
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          if (diff_over) begin
            pend_q  <= b_plus;
            state_q <= S_DONE;
          end else if (llen_q == '0) begin
            pend_q  <= m_e;
            state_q <= S_DONE;
          end else begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          // row minima never decrease, so the last row decides the early exit
          if (ctl_w[MAX_LEN].valid && ctl_w[MAX_LEN].last) begin
            pend_q  <= (EW'(min_w[MAX_LEN]) > b_e) ? b_plus : EW'(left_w[MAX_LEN]);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            out_valid_q      <= 1'b1;
            out_q.distance   <= (pend_q > EW'(bed_pkg::DIST_SAT)) ? bed_pkg::DIST_SAT
                                                                  : pend_q[bed_pkg::DIST_W-1:0];
            out_q.over_limit <= (pend_q > b_e);
            out_q.truncated  <= cut_q;
            llen_q           <= '0;
            rlen_q           <= '0;
            cut_q            <= 1'b0;
            state_q          <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/bed_checker.sv =====
// Port-level checker for the bounded edit distance block, with its bind.
`default_nettype none

module bed_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire bed_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire bed_pkg::out_item_t out_item_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output transaction changed under stall");

  // a closing transaction starts the computation, input is held off next cycle
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.last) |=> in_stall_o)
    else $error("input not stalled after last");

  // a within-bound distance fits the bound register range
  a_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.over_limit) |-> (out_item_o.distance < 6'd32))
    else $error("distance within bound exceeds 31");

  // a new result only appears out of the busy phase
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

  a_over_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.over_limit) |-> (out_item_o.distance != 6'd0))
    else $error("over_limit with zero distance");

endmodule

bind bounded_edit_distance bed_checker u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== test/bed_distance_checker.sv =====
// Checker for bounded_edit_distance: tracks both channels, predicts each distance and scores it.
module bed_distance_checker #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bed_pkg::BOUND_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  bed_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  bed_pkg::out_item_t          out_item_i,
  output int                          mismatch_count_o,
  output int                          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [bed_pkg::BOUND_W-1:0] bound_q = bed_pkg::BOUND_RESET;
  logic [bed_pkg::CHAR_W-1:0]  left_text  [MAX_LEN];
  logic [bed_pkg::CHAR_W-1:0]  right_text [MAX_LEN];
  int unsigned                 left_len   = 0;
  int unsigned                 right_len  = 0;
  bit                          cut_seen   = 1'b0;
  bed_pkg::out_item_t          pending_distances[$];
  int                          mismatches = 0;

  function automatic int unsigned bounded_levenshtein();
    int unsigned above [MAX_LEN+1];
    int unsigned here  [MAX_LEN+1];
    int unsigned n, m, lim, r, c, row_min, diag, best;
    bit          same;
    n    = left_len;
    m    = right_len;
    lim  = bound_q;
    same = (n == m);
    for (c = 0; c < n; c++)
      if (same && left_text[c] != right_text[c]) same = 1'b0;
    if (same) return 0;
    if (n > m + lim || m > n + lim) return lim + 1;
    for (c = 0; c <= m; c++) above[c] = c;
    for (r = 1; r <= n; r++) begin
      here[0] = r;
      row_min = r;
      for (c = 1; c <= m; c++) begin
        diag = above[c-1] + ((left_text[r-1] == right_text[c-1]) ? 0 : 1);
        best = above[c] + 1;
        if (here[c-1] + 1 < best) best = here[c-1] + 1;
        if (diag < best) best = diag;
        here[c] = best;
        if (best < row_min) row_min = best;
      end
      if (row_min > lim) return lim + 1;
      above = here;
    end
    return above[m];
  endfunction

  task automatic absorb(input bed_pkg::in_item_t it);
    bed_pkg::out_item_t want;
    int unsigned        d;
    if (it.left_valid) begin
      if (left_len < MAX_LEN) begin
        left_text[left_len] = it.left_char;
        left_len++;
      end else begin
        cut_seen = 1'b1;
      end
    end
    if (it.right_valid) begin
      if (right_len < MAX_LEN) begin
        right_text[right_len] = it.right_char;
        right_len++;
      end else begin
        cut_seen = 1'b1;
      end
    end
    if (it.last) begin
      d               = bounded_levenshtein();
      want.distance   = (d > bed_pkg::DIST_SAT) ? bed_pkg::DIST_SAT : d[bed_pkg::DIST_W-1:0];
      want.over_limit = (d > bound_q);
      want.truncated  = cut_seen;
      pending_distances.insert(pending_distances.size(), want);
      left_len  = 0;
      right_len = 0;
      cut_seen  = 1'b0;
    end
  endtask

  task automatic flag(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic score(input bed_pkg::out_item_t got);
    bed_pkg::out_item_t want;
    if (pending_distances.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected transaction, expected none, got dist=%0d over=%0b trunc=%0b",
               $time, got.distance, got.over_limit, got.truncated);
    end else begin
      want = pending_distances.pop_front();
      if (got.distance !== want.distance) flag("distance", want.distance, got.distance);
      if (got.over_limit !== want.over_limit)
        flag("over_limit", want.over_limit, got.over_limit);
      if (got.truncated !== want.truncated) flag("truncated", want.truncated, got.truncated);
    end
  endtask

  // Results leave before the pair closing at the same edge is modeled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) bound_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) score(out_item_i);
      if (in_valid_i && !in_stall_i) absorb(in_item_i);
      mismatch_count_o <= mismatches;
      outstanding_o    <= pending_distances.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for bounded_edit_distance: clock, reset, stimulus, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN      = 32;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 80;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned IDLE_PCT     = 13;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [bed_pkg::BOUND_W-1:0] cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  bed_pkg::in_item_t           in_item;
  logic                        out_valid;
  logic                        out_stall;
  bed_pkg::out_item_t          out_item;
  int                          mismatch_count;
  int                          outstanding;

  bit                          idle_en;
  bit                          hold_req;
  logic [7:0]                  left_text[$];
  logic [7:0]                  right_text[$];
  logic [bed_pkg::BOUND_W-1:0] phase_bound[PHASES];
  int unsigned                 cur_bound      = bed_pkg::BOUND_RESET;
  int unsigned                 items_sent     = 0;
  int unsigned                 pairs_sent     = 0;
  int unsigned                 overlong_pairs = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  bounded_edit_distance #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  bed_distance_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_item),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_item(input bed_pkg::in_item_t it);
    if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_pair();
    int unsigned       lp, rp;
    bit                trailer, closed;
    bed_pkg::in_item_t it;
    lp      = 0;
    rp      = 0;
    closed  = 1'b0;
    trailer = ($urandom_range(0, 9) == 0);
    if (left_text.size() > MAX_LEN || right_text.size() > MAX_LEN) overlong_pairs++;
    while (lp < left_text.size() || rp < right_text.size()) begin
      it.left_char   = 8'($urandom);
      it.right_char  = 8'($urandom);
      it.left_valid  = (lp < left_text.size()) && ($urandom_range(0, 9) != 0);
      it.right_valid = (rp < right_text.size()) && ($urandom_range(0, 9) != 0);
      if (it.left_valid) begin
        it.left_char = left_text[lp];
        lp++;
      end
      if (it.right_valid) begin
        it.right_char = right_text[rp];
        rp++;
      end
      it.last = !trailer && lp == left_text.size() && rp == right_text.size();
      closed  = it.last;
      push_item(it);
    end
    if (!closed) begin
      it.left_char   = 8'($urandom);
      it.right_char  = 8'($urandom);
      it.left_valid  = 1'b0;
      it.right_valid = 1'b0;
      it.last        = 1'b1;
      push_item(it);
    end
    pairs_sent++;
  endtask

  task automatic load_text(input string l, input string r);
    int i;
    left_text.delete();
    right_text.delete();
    for (i = 0; i < l.len(); i++) left_text.insert(left_text.size(), l[i]);
    for (i = 0; i < r.len(); i++) right_text.insert(right_text.size(), r[i]);
  endtask

  // Mostly near-miss pairs over a four-letter alphabet so rows stay under the bound.
  task automatic build_pair();
    int unsigned kind, len, edits, pos, i, op;
    logic [7:0]  base;
    left_text.delete();
    right_text.delete();
    kind = $urandom_range(0, 99);
    base = 8'($urandom);
    if (kind < 5) len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
    else if (kind < 12) len = $urandom_range(13, MAX_LEN);
    else len = $urandom_range(0, 12);
    for (i = 0; i < len; i++)
      left_text.insert(left_text.size(),
                       (kind % 4 == 0) ? 8'($urandom) : base + 8'($urandom_range(0, 3)));
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      right_text = left_text;
    end else if (kind < 8) begin
      right_text = left_text;
      edits = $urandom_range(0, cur_bound + 3);
      for (i = 0; i < edits; i++) begin
        op  = $urandom_range(0, 2);
        pos = $urandom_range(0, right_text.size());
        if (op == 0 || right_text.size() == 0) begin
          right_text.insert(pos, base + 8'($urandom_range(0, 3)));
        end else begin
          if (pos == right_text.size()) pos = pos - 1;
          if (op == 1) right_text.delete(pos);
          else right_text[pos] = right_text[pos] ^ 8'($urandom_range(1, 255));
        end
      end
    end else begin
      len = $urandom_range(0, 12);
      for (i = 0; i < len; i++)
        right_text.insert(right_text.size(), base + 8'($urandom_range(0, 3)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_bound(input logic [bed_pkg::BOUND_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_bound = value;
  endtask

  initial begin : stimulus
    int unsigned target, ph;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item  <= '0;
    idle_en  <= 1'b1;
    hold_req <= 1'b0;
    phase_bound[0] = 5'd0;
    phase_bound[1] = 5'd31;
    phase_bound[2] = 5'd1;
    phase_bound[3] = 5'($urandom_range(2, 30));
    phase_bound[4] = 5'd5;
    phase_bound[5] = 5'd31;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    load_text("", "");
    send_pair();
    load_text("ab", "ab");
    send_pair();
    load_text("kitten", "sitting");
    send_pair();
    left_text  = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
    right_text.delete();
    send_pair();
    left_text.delete();
    right_text = '{8'hFF, 8'h00, 8'h7F};
    send_pair();
    load_text("xaaa", "aaab");
    send_pair();

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      set_bound(phase_bound[ph]);
      idle_en <= (ph != 2);
      if (ph == 3) hold_req <= 1'b1;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        build_pair();
        send_pair();
      end
    end
    drain();

    $display("Covered %0d string pairs in %0d input transactions, %0d with an overlong string,",
             pairs_sent, items_sent, overlong_pairs);
    $display("bounds from 0 to 31, gaps and trailers, a no-idle phase and a long output hold-off.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
